// ----- rtl/ils_pkg.sv -----
// Shared types and constants for the indentation level line scanner.
package ils_pkg;

   localparam int KIND_W  = 2;
   localparam int LINE_W  = 16;
   localparam int COL_W   = 12;
   localparam int LEVEL_W = 5;

   localparam logic [7:0]        CHAR_SPACE    = 8'd32;
   localparam logic [7:0]        CHAR_TAB      = 8'd9;
   localparam logic [7:0]        COMMENT_RESET = 8'd35;
   localparam logic [LINE_W-1:0] LINE_MAX      = '1;

   // Report kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LINE       = 2'd0,
      KIND_TAB        = 2'd1,
      KIND_BAD_INDENT = 2'd2,
      KIND_OVERFLOW   = 2'd3
   } kind_type;

   // One result entry
   typedef struct packed {
      kind_type            report_kind;
      logic [LINE_W-1:0]   line_number;
      logic [COL_W-1:0]    column;
      logic [COL_W-1:0]    end_column;
      logic [LEVEL_W-1:0]  level;
      logic                last;
   } result_type;

endpackage

// ----- rtl/ils_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ils_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/ils_fifo.sv -----
// Small register-based FIFO used for the job queue and the result queue.
module ils_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = $clog2(DEPTH),
   localparam int CNTW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/ils_front.sv -----
// Front end: per-character line tracking, comment register, job generation.
module ils_front #(
   parameter int MAX_COLUMNS = 4096,
   localparam int CW = $clog2(MAX_COLUMNS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_wdata,
   input  logic                       accept,
   input  logic [7:0]                 char_code,
   input  logic                       end_of_line,
   input  logic                       start_of_file,
   output logic                       job_push,
   output logic                       job_eol,
   output logic                       job_clear,
   output logic [ils_pkg::LINE_W-1:0] job_line,
   output logic [CW-1:0]              job_column,
   output logic [CW-1:0]              job_start,
   output logic [CW-1:0]              job_end
);
   import ils_pkg::*;

   localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMNS - 1);

   logic [7:0]        comment_ff;
   logic [CW-1:0]     col_ff, col_in;
   logic [CW-1:0]     lead_ff, lead_in;
   logic              at_start_ff, at_start_in;
   logic              in_cmt_ff, in_cmt_in;
   logic [CW-1:0]     cstart_ff, cstart_in;
   logic [CW-1:0]     cend_ff, cend_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              clear_ff, clear_in;
   logic [LINE_W-1:0] line_base, line_next;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v >= COL_MAX) ? COL_MAX : v + 1'b1;
   endfunction

   assign csr_ready = 1'b1;

   // start of file restarts the line count before this request
   assign line_base = start_of_file ? '0 : line_ff;
   assign line_next = (line_base == LINE_MAX) ? LINE_MAX : line_base + 1'b1;

   // job payload; tab jobs use the column, line-end jobs the leading spaces
   assign job_eol    = end_of_line;
   assign job_clear  = clear_ff | start_of_file;
   assign job_line   = line_next;
   assign job_column = end_of_line ? lead_ff : col_ff;
   assign job_start  = cstart_ff;
   assign job_end    = cend_ff;

   // character classification and line state
   always_comb begin
      col_in      = col_ff;
      lead_in     = lead_ff;
      at_start_in = at_start_ff;
      in_cmt_in   = in_cmt_ff;
      cstart_in   = cstart_ff;
      cend_in     = cend_ff;
      line_in     = line_ff;
      clear_in    = clear_ff;
      job_push    = 1'b0;
      if (accept) begin
         line_in = line_base;
         if (end_of_line) begin
            job_push    = 1'b1;
            line_in     = line_next;
            col_in      = '0;
            lead_in     = '0;
            at_start_in = 1'b1;
            in_cmt_in   = 1'b0;
            cstart_in   = '0;
            cend_in     = '0;
         end else if (!in_cmt_ff) begin
            if (char_code == CHAR_SPACE) begin
               if (at_start_ff) begin
                  lead_in = sat_inc(lead_ff);
               end
               col_in = sat_inc(col_ff);
            end else if (char_code == CHAR_TAB) begin
               job_push = 1'b1;
               col_in   = sat_inc(col_ff);
            end else if (char_code == comment_ff) begin
               in_cmt_in = 1'b1;
            end else begin
               if (at_start_ff) begin
                  cstart_in = col_ff;
               end
               at_start_in = 1'b0;
               cend_in     = sat_inc(col_ff);
               col_in      = sat_inc(col_ff);
            end
         end
         // a stack clear rides on the next job
         clear_in = job_push ? 1'b0 : (start_of_file | clear_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff  <= COMMENT_RESET;
         col_ff      <= '0;
         lead_ff     <= '0;
         at_start_ff <= 1'b1;
         in_cmt_ff   <= 1'b0;
         cstart_ff   <= '0;
         cend_ff     <= '0;
         line_ff     <= '0;
         clear_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            comment_ff <= csr_wdata;
         end
         col_ff      <= col_in;
         lead_ff     <= lead_in;
         at_start_ff <= at_start_in;
         in_cmt_ff   <= in_cmt_in;
         cstart_ff   <= cstart_in;
         cend_ff     <= cend_in;
         line_ff     <= line_in;
         clear_ff    <= clear_in;
      end
   end

endmodule

// ----- rtl/ils_back.sv -----
// Back end: indentation stack push/pop sequencer and result generation.
module ils_back #(
   parameter int STACK_DEPTH = 32,
   parameter int MAX_COLUMNS = 4096,
   localparam int CW = $clog2(MAX_COLUMNS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   output logic                       job_pop,
   input  logic                       job_eol,
   input  logic                       job_clear,
   input  logic [ils_pkg::LINE_W-1:0] job_line,
   input  logic [CW-1:0]              job_column,
   input  logic [CW-1:0]              job_start,
   input  logic [CW-1:0]              job_end,
   input  logic                       res_full,
   output logic                       res_push,
   output ils_pkg::result_type        res_data
);
   import ils_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_EVAL     = 6'b000010,
      S_DEDENT   = 6'b000100,
      S_POP_WAIT = 6'b001000,
      S_EMIT_ERR = 6'b010000,
      S_EMIT_LN  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic              eol_ff, eol_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [CW-1:0]     ls_ff, ls_in;
   logic [CW-1:0]     cs_ff, cs_in;
   logic [CW-1:0]     ce_ff, ce_in;
   logic [AW-1:0]     sp_ff, sp_in;
   logic [CW-1:0]     top_ff, top_in;
   kind_type          err_ff, err_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CW-1:0]     ram_rdata;
   logic              room;

   ils_ram #(
      .WIDTH (CW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ls_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // another level fits above the current top
   assign room      = ((AW + 1)'(sp_ff) + 1'b1) < (AW + 1)'(STACK_DEPTH);
   assign ram_waddr = sp_ff + 1'b1;
   assign ram_raddr = sp_ff - 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      eol_in   = eol_ff;
      line_in  = line_ff;
      ls_in    = ls_ff;
      cs_in    = cs_ff;
      ce_in    = ce_ff;
      sp_in    = sp_ff;
      top_in   = top_ff;
      err_in   = err_ff;
      job_pop  = 1'b0;
      ram_we   = 1'b0;
      ram_re   = 1'b0;
      res_push = 1'b0;
      res_data = '{report_kind: KIND_LINE, line_number: line_ff,
                   column: COL_W'(cs_ff), end_column: COL_W'(ce_ff),
                   level: LEVEL_W'(sp_ff), last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               eol_in   = job_eol;
               line_in  = job_line;
               ls_in    = job_column;
               cs_in    = job_start;
               ce_in    = job_end;
               if (job_clear) begin
                  sp_in  = '0;
                  top_in = '0;
               end
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!eol_ff) begin
               err_in   = KIND_TAB;
               state_in = S_EMIT_ERR;
            end else if (ls_ff > top_ff) begin
               if (room) begin
                  ram_we   = 1'b1;
                  sp_in    = sp_ff + 1'b1;
                  top_in   = ls_ff;
                  state_in = S_EMIT_LN;
               end else begin
                  err_in   = KIND_OVERFLOW;
                  state_in = S_EMIT_ERR;
               end
            end else if (ls_ff < top_ff) begin
               state_in = S_DEDENT;
            end else begin
               state_in = S_EMIT_LN;
            end
         end
         S_DEDENT: begin
            if (sp_ff != '0 && ls_ff < top_ff) begin
               ram_re   = 1'b1;
               state_in = S_POP_WAIT;
            end else if (ls_ff != top_ff) begin
               err_in   = KIND_BAD_INDENT;
               state_in = S_EMIT_ERR;
            end else begin
               state_in = S_EMIT_LN;
            end
         end
         S_POP_WAIT: begin
            // bottom entry is never written; its zero level is used here instead of the read data
            sp_in    = sp_ff - 1'b1;
            top_in   = (sp_ff == AW'(1)) ? '0 : ram_rdata;
            state_in = S_DEDENT;
         end
         S_EMIT_ERR: begin
            res_data = '{report_kind: err_ff, line_number: line_ff,
                         column: COL_W'(ls_ff), end_column: '0,
                         level: '0, last: ~eol_ff};
            if (!res_full) begin
               res_push = 1'b1;
               state_in = eol_ff ? S_EMIT_LN : S_IDLE;
            end
         end
         S_EMIT_LN: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         top_ff   <= top_in;
      end
   end

   // job payload, no reset
   always_ff @(posedge clock) begin
      eol_ff  <= eol_in;
      line_ff <= line_in;
      ls_ff   <= ls_in;
      cs_ff   <= cs_in;
      ce_ff   <= ce_in;
      err_ff  <= err_in;
   end

endmodule

// ----- rtl/indentation_level_line_scanner.sv -----
// Top level: offside-rule indentation scanner with decoupled front and back ends.
// Front end takes one request per cycle while its 4-entry job queue has room.
// Back end takes one job at a time: a tab job gives one error result; a line-end job passes
// EVAL, a DEDENT/POP_WAIT pair per popped level, any error result, then the line result.
// Synchronous active-high reset clears control state, empties both queues, empties
// the indentation stack and sets the comment character to 35; no clearing pass.
module indentation_level_line_scanner #(
   parameter int STACK_DEPTH = 32,
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_end_of_line,
   input  logic                        req_start_of_file,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [ils_pkg::KIND_W-1:0]  rsp_report_kind,
   output logic [ils_pkg::LINE_W-1:0]  rsp_line_number,
   output logic [ils_pkg::COL_W-1:0]   rsp_column,
   output logic [ils_pkg::COL_W-1:0]   rsp_end_column,
   output logic [ils_pkg::LEVEL_W-1:0] rsp_level,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_wdata
);
   import ils_pkg::*;

   localparam int CW      = $clog2(MAX_COLUMNS);
   localparam int JOB_W   = 2 + LINE_W + 3 * CW;
   localparam int RES_W   = $bits(result_type);
   localparam int Q_DEPTH = 4;

   logic              accept;
   logic              job_push, job_full, job_pop, job_empty;
   logic              f_eol, f_clear, b_eol, b_clear;
   logic [LINE_W-1:0] f_line, b_line;
   logic [CW-1:0]     f_col, f_start, f_end, b_col, b_start, b_end;
   logic [JOB_W-1:0]  job_wdata, job_rdata;
   logic              res_push, res_full;
   result_type        res_data, rsp_word;
   logic [RES_W-1:0]  rsp_bits;

   assign accept    = req_push & ~job_full;
   assign req_full  = job_full;

   ils_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .char_code     (req_char_code),
      .end_of_line   (req_end_of_line),
      .start_of_file (req_start_of_file),
      .job_push      (job_push),
      .job_eol       (f_eol),
      .job_clear     (f_clear),
      .job_line      (f_line),
      .job_column    (f_col),
      .job_start     (f_start),
      .job_end       (f_end)
   );

   // job queue between front and back
   assign job_wdata = {f_eol, f_clear, f_line, f_col, f_start, f_end};
   assign {b_eol, b_clear, b_line, b_col, b_start, b_end} = job_rdata;

   ils_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (Q_DEPTH)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   ils_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_pop    (job_pop),
      .job_eol    (b_eol),
      .job_clear  (b_clear),
      .job_line   (b_line),
      .job_column (b_col),
      .job_start  (b_start),
      .job_end    (b_end),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // result queue toward the consumer
   ils_fifo #(
      .WIDTH (RES_W),
      .DEPTH (Q_DEPTH)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_word        = result_type'(rsp_bits);
   assign rsp_report_kind = rsp_word.report_kind;
   assign rsp_line_number = rsp_word.line_number;
   assign rsp_column      = rsp_word.column;
   assign rsp_end_column  = rsp_word.end_column;
   assign rsp_level       = rsp_word.level;
   assign rsp_last        = rsp_word.last;

`ifndef SYNTHESIS
   // front never produces a job the queue cannot take
   a_job_no_overrun: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job written while queue full");

   // back never produces a result the queue cannot take
   a_res_no_overrun: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result written while queue full");

   // a line report always closes the request
   a_line_is_last: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.report_kind == KIND_LINE) |-> res_data.last)
      else $error("line report not marked last");

   // error reports carry no span and no level
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.report_kind != KIND_LINE)
         |-> (res_data.end_column == '0 && res_data.level == '0))
      else $error("error report with span or level");
`endif

endmodule
